@@ rtl/assert_macros.svh @@
// Assertion helpers included by the ALU RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/aaf8_pkg.sv @@
package aaf8_pkg;

   // Operation codes
   typedef enum logic [4:0] {
      OP_ADD        = 5'd0,
      OP_ADC        = 5'd1,
      OP_SUB        = 5'd2,
      OP_SBB        = 5'd3,
      OP_AND        = 5'd4,
      OP_XOR        = 5'd5,
      OP_OR         = 5'd6,
      OP_CMP        = 5'd7,
      OP_INR        = 5'd8,
      OP_DCR        = 5'd9,
      OP_RLC        = 5'd10,
      OP_RRC        = 5'd11,
      OP_RAL        = 5'd12,
      OP_RAR        = 5'd13,
      OP_DAA        = 5'd14,
      OP_CMA        = 5'd15,
      OP_STC        = 5'd16,
      OP_CMC        = 5'd17,
      OP_DAD        = 5'd18,
      OP_LOAD_A     = 5'd19,
      OP_LOAD_HL    = 5'd20,
      OP_LOAD_FLAGS = 5'd21
   } opcode_type;

   // Channel widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // Decimal adjust constants
   localparam logic [3:0] DAA_NIBBLE_MAX = 4'h9;
   localparam logic [7:0] DAA_BYTE_MAX   = 8'h99;
   localparam logic [7:0] DAA_LOW_CORR   = 8'h06;
   localparam logic [7:0] DAA_HIGH_CORR  = 8'h60;

   // Input item fields
   typedef struct packed {
      logic [15:0] pair_operand;
      logic [7:0]  operand;
      logic [4:0]  opcode;
   } req_item_type;

   // Eight-bit adder result with its carries
   typedef struct packed {
      logic       cy;
      logic       ac;
      logic [7:0] sum;
   } add_type;

   function automatic add_type add8(input logic [7:0] a, input logic [7:0] b,
                                    input logic cin);
      logic [8:0] full;
      logic [4:0] low;
      add_type    res;
      full    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
      low     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
      res.cy  = full[8];
      res.ac  = low[4];
      res.sum = full[7:0];
      return res;
   endfunction

   // Flag byte layout: S Z 0 AC 0 P 1 CY
   function automatic logic [7:0] pack_flags(input logic s, input logic z, input logic ac,
                                             input logic p, input logic cy);
      return {s, z, 1'b0, ac, 1'b0, p, 1'b1, cy};
   endfunction

endpackage

@@ rtl/alu_accumulator_flags_8bit.sv @@
// 8080-style ALU holding A, HL and the flags CY, AC, Z, S, P. Each request item carries an
// opcode, an operand byte and a 16-bit pair; each produces exactly one response item with
// the 8-bit result, the new A, the new HL and the packed flag byte (S Z 0 AC 0 P 1 CY).
// Items are taken one per clock while the output is not stalled; a response is valid
// once its item has passed the input register, then the ALU into the response register.
// The rate is set by the loop through the ALU from the accumulator and flag registers
// back to themselves, so each item sees the state left by the one before it.
// A waiting response holds back the input register but the block still takes one item
// into it. Reset clears A, HL and all flags.
module alu_accumulator_flags_8bit (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: opcode[4:0], operand[12:5], pair_operand[28:13], zero fill [31:29]
   input  logic [aaf8_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rsp_tdata: result[7:0], accumulator_out[15:8], hl_out[31:16], flag_byte[39:32]
   output logic [aaf8_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);

`include "assert_macros.svh"

   // Input register
   logic                  s1_valid_ff;
   aaf8_pkg::req_item_type s1_item_ff;

   // Architectural state
   logic [7:0]  acc_ff, acc_in;
   logic [15:0] hl_ff, hl_in;
   logic        cy_ff, cy_in;
   logic        ac_ff, ac_in;
   logic        z_ff, z_in;
   logic        s_ff, s_in;
   logic        p_ff, p_in;

   // Response register
   logic                            out_valid_ff;
   logic [aaf8_pkg::RSP_DATA_W-1:0] out_data_ff;

   logic out_free;
   logic s1_move;

   // Handshake: output stage frees when empty or taken; input stage when it moves on
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_item_ff <= aaf8_pkg::req_item_type'(req_tdata[28:0]);
      end
   end

   // ALU
   logic [7:0]       opnd;
   logic [15:0]      pair;
   logic [7:0]       res;
   logic             zsp_upd;
   logic [16:0]      dad_sum;
   logic [7:0]       daa_corr;
   logic             daa_high;
   aaf8_pkg::add_type add_r;
   aaf8_pkg::add_type inr_r;
   aaf8_pkg::add_type dcr_r;
   aaf8_pkg::add_type daa_r;
   logic             add_cin;
   logic [7:0]       add_b;

   assign opnd = s1_item_ff.operand;
   assign pair = s1_item_ff.pair_operand;

   always_comb begin
      // Shared adder for add/adc/sub/sbb/cmp
      add_b   = opnd;
      add_cin = 1'b0;
      unique case (s1_item_ff.opcode)
         aaf8_pkg::OP_ADC: begin
            add_cin = cy_ff;
         end
         aaf8_pkg::OP_SUB, aaf8_pkg::OP_CMP: begin
            add_b   = ~opnd;
            add_cin = 1'b1;
         end
         aaf8_pkg::OP_SBB: begin
            add_b   = ~opnd;
            add_cin = !cy_ff;
         end
         default: begin
            add_b   = opnd;
            add_cin = 1'b0;
         end
      endcase
   end

   assign add_r = aaf8_pkg::add8(acc_ff, add_b, add_cin);
   assign inr_r = aaf8_pkg::add8(opnd, 8'h01, 1'b0);
   assign dcr_r = aaf8_pkg::add8(opnd, 8'hff, 1'b0);

   // Decimal adjust correction
   always_comb begin
      daa_corr = 8'h00;
      daa_high = (acc_ff > aaf8_pkg::DAA_BYTE_MAX) || cy_ff;
      if ((acc_ff[3:0] > aaf8_pkg::DAA_NIBBLE_MAX) || ac_ff) begin
         daa_corr = daa_corr | aaf8_pkg::DAA_LOW_CORR;
      end
      if (daa_high) begin
         daa_corr = daa_corr | aaf8_pkg::DAA_HIGH_CORR;
      end
   end

   assign daa_r   = aaf8_pkg::add8(acc_ff, daa_corr, 1'b0);
   assign dad_sum = {1'b0, hl_ff} + {1'b0, pair};

   // Next state and result
   always_comb begin
      acc_in  = acc_ff;
      hl_in   = hl_ff;
      cy_in   = cy_ff;
      ac_in   = ac_ff;
      z_in    = z_ff;
      s_in    = s_ff;
      p_in    = p_ff;
      res     = 8'h00;
      zsp_upd = 1'b0;
      unique case (s1_item_ff.opcode)
         aaf8_pkg::OP_ADD, aaf8_pkg::OP_ADC: begin
            res     = add_r.sum;
            cy_in   = add_r.cy;
            ac_in   = add_r.ac;
            acc_in  = add_r.sum;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_SUB, aaf8_pkg::OP_SBB: begin
            res     = add_r.sum;
            cy_in   = !add_r.cy;
            ac_in   = add_r.ac;
            acc_in  = add_r.sum;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_CMP: begin
            res     = add_r.sum;
            cy_in   = !add_r.cy;
            ac_in   = add_r.ac;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_AND: begin
            res     = acc_ff & opnd;
            cy_in   = 1'b0;
            ac_in   = acc_ff[3] | opnd[3];
            acc_in  = acc_ff & opnd;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_XOR: begin
            res     = acc_ff ^ opnd;
            cy_in   = 1'b0;
            ac_in   = 1'b0;
            acc_in  = acc_ff ^ opnd;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_OR: begin
            res     = acc_ff | opnd;
            cy_in   = 1'b0;
            ac_in   = 1'b0;
            acc_in  = acc_ff | opnd;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_INR: begin
            res     = inr_r.sum;
            ac_in   = inr_r.ac;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_DCR: begin
            res     = dcr_r.sum;
            ac_in   = dcr_r.ac;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_RLC: begin
            res    = {acc_ff[6:0], acc_ff[7]};
            acc_in = {acc_ff[6:0], acc_ff[7]};
            cy_in  = acc_ff[7];
         end
         aaf8_pkg::OP_RRC: begin
            res    = {acc_ff[0], acc_ff[7:1]};
            acc_in = {acc_ff[0], acc_ff[7:1]};
            cy_in  = acc_ff[0];
         end
         aaf8_pkg::OP_RAL: begin
            res    = {acc_ff[6:0], cy_ff};
            acc_in = {acc_ff[6:0], cy_ff};
            cy_in  = acc_ff[7];
         end
         aaf8_pkg::OP_RAR: begin
            res    = {cy_ff, acc_ff[7:1]};
            acc_in = {cy_ff, acc_ff[7:1]};
            cy_in  = acc_ff[0];
         end
         aaf8_pkg::OP_DAA: begin
            res     = daa_r.sum;
            acc_in  = daa_r.sum;
            ac_in   = daa_r.ac;
            cy_in   = cy_ff | daa_high;
            zsp_upd = 1'b1;
         end
         aaf8_pkg::OP_CMA: begin
            res    = ~acc_ff;
            acc_in = ~acc_ff;
         end
         aaf8_pkg::OP_STC: begin
            cy_in = 1'b1;
         end
         aaf8_pkg::OP_CMC: begin
            cy_in = !cy_ff;
         end
         aaf8_pkg::OP_DAD: begin
            hl_in = dad_sum[15:0];
            cy_in = dad_sum[16];
         end
         aaf8_pkg::OP_LOAD_A: begin
            res    = opnd;
            acc_in = opnd;
         end
         aaf8_pkg::OP_LOAD_HL: begin
            hl_in = pair;
         end
         aaf8_pkg::OP_LOAD_FLAGS: begin
            s_in  = opnd[7];
            z_in  = opnd[6];
            ac_in = opnd[4];
            p_in  = opnd[2];
            cy_in = opnd[0];
         end
         default: begin
            // unused codes change nothing
            res = 8'h00;
         end
      endcase
      if (zsp_upd) begin
         z_in = (res == 8'h00);
         s_in = res[7];
         p_in = ~^res;
      end
   end

   // State commits when the item moves into the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 8'h00;
         hl_ff  <= 16'h0000;
         cy_ff  <= 1'b0;
         ac_ff  <= 1'b0;
         z_ff   <= 1'b0;
         s_ff   <= 1'b0;
         p_ff   <= 1'b0;
      end else if (s1_move) begin
         acc_ff <= acc_in;
         hl_ff  <= hl_in;
         cy_ff  <= cy_in;
         ac_ff  <= ac_in;
         z_ff   <= z_in;
         s_ff   <= s_in;
         p_ff   <= p_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff <= {aaf8_pkg::pack_flags(s_in, z_in, ac_in, p_in, cy_in),
                         hl_in, acc_in, res};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Checks
   `ASSERT_NEXT(a_state_holds_on_stall, clock, reset, out_valid_ff && !rsp_tready, $stable(acc_ff) && $stable(hl_ff) && $stable(cy_ff), "state changed while response stalled")
   `ASSERT_SAME(a_rsp_matches_state, clock, reset, out_valid_ff, (out_data_ff[15:8] == acc_ff) && (out_data_ff[31:16] == hl_ff), "response A/HL differ from state")
   `ASSERT_SAME(a_flag_fixed_bits, clock, reset, out_valid_ff, out_data_ff[33] && !out_data_ff[35] && !out_data_ff[37], "flag byte fixed bits wrong")
   `ASSERT_SAME(a_rsp_carry_matches, clock, reset, out_valid_ff, out_data_ff[32] == cy_ff, "response carry differs from state")

endmodule

@@ bench/alu_accumulator_flags_8bit_tb.sv @@
`timescale 1ns / 100ps

// Expected response fields, packed as on rsp_tdata (result in the lowest bits)
typedef struct packed {
   logic [7:0]  flag_byte;
   logic [15:0] hl_out;
   logic [7:0]  accumulator_out;
   logic [7:0]  result;
} alu_rsp_type;

// Tracks the ALU state, predicts each response and checks what comes out
class alu_flag_scoreboard;
   logic [7:0]  acc;
   logic [15:0] hl;
   logic        cy, ac, zf, sf, pf;
   alu_rsp_type expected_rsp_q[$];
   int          items_noted;
   int          rsps_checked;
   int          mismatches;

   function new();
      acc = 8'h00;
      hl = 16'h0000;
      cy = 1'b0;
      ac = 1'b0;
      zf = 1'b0;
      sf = 1'b0;
      pf = 1'b0;
      items_noted = 0;
      rsps_checked = 0;
      mismatches = 0;
   endfunction

   // a + b + cin, leaving carry out of bit 7 and of bit 3 in CY and AC
   function logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b, input logic cin);
      logic [8:0] full;
      logic [4:0] low;
      full = {1'b0, a} + {1'b0, b} + 9'(cin);
      low = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin);
      cy = full[8];
      ac = low[4];
      return full[7:0];
   endfunction

   function void update_zsp(input logic [7:0] v);
      zf = (v == 8'h00);
      sf = v[7];
      pf = ~^v;
   endfunction

   function int pending();
      return expected_rsp_q.size();
   endfunction

   // Apply one accepted item to the shadow state and queue its response
   function void note_item(input aaf8_pkg::req_item_type it);
      logic [7:0]  a, x, r, corr;
      logic [16:0] wide;
      logic        keep;
      alu_rsp_type exp_rsp;
      a = acc;
      x = it.operand;
      r = 8'h00;
      case (it.opcode)
         aaf8_pkg::OP_ADD: begin
            r = carry_add(a, x, 1'b0); update_zsp(r); acc = r;
         end
         aaf8_pkg::OP_ADC: begin
            r = carry_add(a, x, cy); update_zsp(r); acc = r;
         end
         aaf8_pkg::OP_SUB: begin
            r = carry_add(a, ~x, 1'b1); cy = ~cy; update_zsp(r); acc = r;
         end
         aaf8_pkg::OP_SBB: begin
            r = carry_add(a, ~x, ~cy); cy = ~cy; update_zsp(r); acc = r;
         end
         aaf8_pkg::OP_AND: begin
            r = a & x; cy = 1'b0; ac = a[3] | x[3]; update_zsp(r); acc = r;
         end
         aaf8_pkg::OP_XOR: begin
            r = a ^ x; cy = 1'b0; ac = 1'b0; update_zsp(r); acc = r;
         end
         aaf8_pkg::OP_OR: begin
            r = a | x; cy = 1'b0; ac = 1'b0; update_zsp(r); acc = r;
         end
         aaf8_pkg::OP_CMP: begin
            r = carry_add(a, ~x, 1'b1); cy = ~cy; update_zsp(r);
         end
         aaf8_pkg::OP_INR: begin
            keep = cy; r = carry_add(x, 8'h01, 1'b0); cy = keep; update_zsp(r);
         end
         aaf8_pkg::OP_DCR: begin
            keep = cy; r = carry_add(x, 8'hff, 1'b0); cy = keep; update_zsp(r);
         end
         aaf8_pkg::OP_RLC: begin
            r = {a[6:0], a[7]}; cy = a[7]; acc = r;
         end
         aaf8_pkg::OP_RRC: begin
            r = {a[0], a[7:1]}; cy = a[0]; acc = r;
         end
         aaf8_pkg::OP_RAL: begin
            r = {a[6:0], cy}; cy = a[7]; acc = r;
         end
         aaf8_pkg::OP_RAR: begin
            r = {cy, a[7:1]}; cy = a[0]; acc = r;
         end
         aaf8_pkg::OP_DAA: begin
            corr = 8'h00;
            keep = cy;
            if (a[3:0] > 4'h9 || ac) corr = corr | 8'h06;
            if (a > 8'h99 || cy) begin
               corr = corr | 8'h60;
               keep = 1'b1;
            end
            r = carry_add(a, corr, 1'b0);
            cy = keep;
            update_zsp(r);
            acc = r;
         end
         aaf8_pkg::OP_CMA: begin
            r = ~a; acc = r;
         end
         aaf8_pkg::OP_STC: cy = 1'b1;
         aaf8_pkg::OP_CMC: cy = ~cy;
         aaf8_pkg::OP_DAD: begin
            wide = {1'b0, hl} + {1'b0, it.pair_operand};
            cy = wide[16];
            hl = wide[15:0];
         end
         aaf8_pkg::OP_LOAD_A: begin
            r = x; acc = x;
         end
         aaf8_pkg::OP_LOAD_HL: hl = it.pair_operand;
         aaf8_pkg::OP_LOAD_FLAGS: begin
            sf = x[7]; zf = x[6]; ac = x[4]; pf = x[2]; cy = x[0];
         end
         default: ;
      endcase
      exp_rsp.result = r;
      exp_rsp.accumulator_out = acc;
      exp_rsp.hl_out = hl;
      exp_rsp.flag_byte = {sf, zf, 1'b0, ac, 1'b0, pf, 1'b1, cy};
      expected_rsp_q.push_back(exp_rsp);
      items_noted++;
   endfunction

   // Compare one response item against the oldest prediction
   function void check_rsp(input logic [aaf8_pkg::RSP_DATA_W-1:0] data);
      alu_rsp_type got, want;
      got = data;
      if (expected_rsp_q.size() == 0) begin
         $error("response item with nothing expected: %010h", data);
         mismatches++;
         return;
      end
      want = expected_rsp_q.pop_front();
      rsps_checked++;
      if (got.result !== want.result) begin
         $error("result: expected %02h, got %02h", want.result, got.result);
         mismatches++;
      end
      if (got.accumulator_out !== want.accumulator_out) begin
         $error("accumulator_out: expected %02h, got %02h",
                want.accumulator_out, got.accumulator_out);
         mismatches++;
      end
      if (got.hl_out !== want.hl_out) begin
         $error("hl_out: expected %04h, got %04h", want.hl_out, got.hl_out);
         mismatches++;
      end
      if (got.flag_byte !== want.flag_byte) begin
         $error("flag_byte: expected %02h, got %02h", want.flag_byte, got.flag_byte);
         mismatches++;
      end
   endfunction
endclass

module alu_accumulator_flags_8bit_tb;

   localparam int PHASE_ITEMS = 350;
   localparam int LONG_STALL = 60;
   localparam int CYCLE_LIMIT = 200000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [aaf8_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [aaf8_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;

   alu_flag_scoreboard    sb = new();
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   bit                    hold_rsp_req = 1'b0;
   int                    cycle_count = 0;

   alu_accumulator_flags_8bit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_rsp(rsp_tdata);
   end

   // Response side: random stalls, plus a long hold-off on request
   initial begin : rsp_side
      int k;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_tready <= 1'b0;
            for (k = 0; k < LONG_STALL; k++) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one item, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_item(input aaf8_pkg::req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {{(aaf8_pkg::REQ_DATA_W - $bits(aaf8_pkg::req_item_type)){1'b0}}, it};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_item(it);
   endtask

   task automatic send_op(input logic [4:0] op, input logic [7:0] x, input logic [15:0] pair);
      aaf8_pkg::req_item_type it;
      it.opcode = op;
      it.operand = x;
      it.pair_operand = pair;
      send_item(it);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Byte with a bias toward carry and decimal boundaries
   function automatic logic [7:0] pick_byte();
      logic [7:0] corners[8] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h0f, 8'h10, 8'h99, 8'h9a};
      if ($urandom_range(7) == 0) return corners[$urandom_range(7)];
      return 8'($urandom_range(255));
   endfunction

   function automatic aaf8_pkg::req_item_type random_alu_item();
      aaf8_pkg::req_item_type it;
      if ($urandom_range(99) < 5) it.opcode = 5'($urandom_range(31, 22));
      else it.opcode = 5'($urandom_range(21));
      it.operand = pick_byte();
      case ($urandom_range(7))
         0: it.pair_operand = 16'h0000;
         1: it.pair_operand = 16'hffff;
         default: it.pair_operand = 16'($urandom_range(65535));
      endcase
      return it;
   endfunction

   function automatic logic [7:0] random_bcd();
      return {4'($urandom_range(9)), 4'($urandom_range(9))};
   endfunction

   // Packed BCD addition followed by decimal adjust
   task automatic send_bcd_add();
      send_op(aaf8_pkg::OP_LOAD_A, random_bcd(), 16'($urandom_range(65535)));
      if ($urandom_range(1))
         send_op(aaf8_pkg::OP_ADC, random_bcd(), 16'($urandom_range(65535)));
      else
         send_op(aaf8_pkg::OP_ADD, random_bcd(), 16'($urandom_range(65535)));
      send_op(aaf8_pkg::OP_DAA, pick_byte(), 16'($urandom_range(65535)));
   endtask

   // Stimulus
   initial begin : stimulus
      int phase, i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every operation, the flag corner cases
      send_op(aaf8_pkg::OP_LOAD_A, 8'hff, 16'h0000);
      send_op(aaf8_pkg::OP_ADD, 8'h01, 16'hffff);        // carry, aux carry and zero together
      send_op(aaf8_pkg::OP_ADC, 8'hff, 16'h0000);        // operand plus carry reaches 256
      send_op(aaf8_pkg::OP_SUB, 8'h00, 16'h0000);        // no borrow on a zero operand
      send_op(aaf8_pkg::OP_STC, 8'h00, 16'h0000);
      send_op(aaf8_pkg::OP_SBB, 8'h00, 16'h0000);        // borrow in with a zero operand
      send_op(aaf8_pkg::OP_SBB, 8'hff, 16'h0000);        // operand plus borrow reaches 256
      send_op(aaf8_pkg::OP_AND, 8'h08, 16'h0000);        // aux carry from bit 3 of A or operand
      send_op(aaf8_pkg::OP_XOR, 8'hff, 16'h0000);
      send_op(aaf8_pkg::OP_OR, 8'h00, 16'h0000);
      send_op(aaf8_pkg::OP_CMP, 8'h80, 16'h0000);
      send_op(aaf8_pkg::OP_INR, 8'hff, 16'h0000);        // wraps, carry kept
      send_op(aaf8_pkg::OP_DCR, 8'h00, 16'h0000);        // wraps, carry kept
      send_op(aaf8_pkg::OP_LOAD_A, 8'h81, 16'h0000);
      send_op(aaf8_pkg::OP_RLC, 8'h00, 16'h0000);
      send_op(aaf8_pkg::OP_RRC, 8'h00, 16'h0000);
      send_op(aaf8_pkg::OP_RAL, 8'h00, 16'h0000);
      send_op(aaf8_pkg::OP_RAR, 8'h00, 16'h0000);
      send_op(aaf8_pkg::OP_LOAD_A, 8'h9b, 16'h0000);
      send_op(aaf8_pkg::OP_DAA, 8'h00, 16'h0000);        // both corrections, carry set
      send_op(aaf8_pkg::OP_LOAD_FLAGS, 8'hff, 16'h0000); // unused bits ignored
      send_op(aaf8_pkg::OP_DAA, 8'h00, 16'h0000);        // corrections forced by AC and CY
      send_op(aaf8_pkg::OP_CMA, 8'h00, 16'h0000);
      send_op(aaf8_pkg::OP_CMC, 8'h00, 16'h0000);
      send_op(aaf8_pkg::OP_LOAD_HL, 8'h00, 16'hffff);
      send_op(aaf8_pkg::OP_DAD, 8'h00, 16'h0001);        // carry out of HL
      send_op(5'd31, 8'hff, 16'hffff);                   // unused opcode
      drain_results();

      // Random: three stall mixes, pausing for all results between them
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 8;  recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 8;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (i == 150 && phase != 1) hold_rsp_req = 1'b1;
            if ($urandom_range(99) < 8) send_bcd_add();
            else send_item(random_alu_item());
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected response items never arrived", sb.pending());
         sb.mismatches++;
      end
      $display("Summary: %0d items sent, %0d responses checked, %0d mismatches",
               sb.items_noted, sb.rsps_checked, sb.mismatches);
      $display("Covered all opcodes, unused codes, BCD adds with adjust and long output stalls");
      if (sb.mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/aaf8_pkg.sv
rtl/alu_accumulator_flags_8bit.sv
bench/alu_accumulator_flags_8bit_tb.sv
